FILE: rtl/pfc_pkg.sv
package pfc_pkg;

	localparam int SIDE     = 5;
	localparam int CELLS    = SIDE * SIDE;
	localparam int ALPHABET = 26;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] coord_t;

	localparam letter_t LETTER_I    = 5'd8;
	localparam letter_t LETTER_J    = 5'd9;
	localparam letter_t LAST_LETTER = 5'd25;
	localparam letter_t FULL_COUNT  = 5'd25;
	localparam coord_t  LAST_COORD  = 3'd4;

	localparam logic [ALPHABET-1:0] PLACED_RESET = ALPHABET'(1) << LETTER_J;

	typedef enum logic [1:0] {
		OP_KEY    = 2'd0,
		OP_FINISH = 2'd1,
		OP_ENC    = 2'd2,
		OP_DEC    = 2'd3
	} op_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_ctrl_t;

	function automatic letter_t fold_j(letter_t l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	function automatic letter_t j_form(letter_t l);
		return (l == LETTER_I) ? LETTER_J : l;
	endfunction

	function automatic coord_t row_of(letter_t c);
		coord_t r;
		if (c inside {[5'd0:5'd4]}) begin
			r = 3'd0;
		end else if (c inside {[5'd5:5'd9]}) begin
			r = 3'd1;
		end else if (c inside {[5'd10:5'd14]}) begin
			r = 3'd2;
		end else if (c inside {[5'd15:5'd19]}) begin
			r = 3'd3;
		end else begin
			r = 3'd4;
		end
		return r;
	endfunction

	function automatic coord_t col_of(letter_t c);
		coord_t  r;
		letter_t r5;
		letter_t d;
		r  = row_of(c);
		r5 = {r, 2'b00} + {2'b00, r};
		d  = c - r5;
		return d[2:0];
	endfunction

	function automatic coord_t step(coord_t x, logic dec);
		coord_t y;
		if (dec) begin
			y = (x == 3'd0) ? LAST_COORD : x - 3'd1;
		end else begin
			y = (x == LAST_COORD) ? 3'd0 : x + 3'd1;
		end
		return y;
	endfunction

	function automatic letter_t cell_index(coord_t r, coord_t c);
		return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

FILE: rtl/pfc_lane.sv
module pfc_lane
	import pfc_pkg::*;
(
	input  logic    clk,
	input  logic    we,
	input  letter_t wdata,
	input  letter_t key_a,
	input  letter_t key_b,
	output letter_t stored,
	output logic    match_a,
	output logic    match_b
);

	letter_t cell_q;

	always_ff @(posedge clk) begin
		if (we) begin
			cell_q <= wdata;
		end
	end

	assign stored  = cell_q;
	assign match_a = (cell_q == key_a);
	assign match_b = (cell_q == key_b);

endmodule

FILE: rtl/pfc_merge.sv
module pfc_merge
	import pfc_pkg::*;
(
	input  logic             clk,
	input  pipe_ctrl_t       ctrl,
	input  logic [CELLS-1:0] match_a,
	input  logic [CELLS-1:0] match_b,
	input  logic             dec,
	output letter_t          tgt_a,
	output letter_t          tgt_b
);

	logic [CELLS-1:0] ma_s1;
	logic [CELLS-1:0] mb_s1;
	logic             dec_s1;
	letter_t          tgt_a_s2;
	letter_t          tgt_b_s2;

	letter_t ca;
	letter_t cb;
	coord_t  ra;
	coord_t  qa;
	coord_t  rb;
	coord_t  qb;
	letter_t na;
	letter_t nb;

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			ma_s1  <= match_a;
			mb_s1  <= match_b;
			dec_s1 <= dec;
		end
		if (ctrl.en_s2) begin
			tgt_a_s2 <= na;
			tgt_b_s2 <= nb;
		end
	end

	always_comb begin
		ca = '0;
		cb = '0;
		for (int k = 0; k < CELLS; k++) begin
			if (ma_s1[k]) begin
				ca = ca | letter_t'(k);
			end
			if (mb_s1[k]) begin
				cb = cb | letter_t'(k);
			end
		end
		ra = row_of(ca);
		qa = col_of(ca);
		rb = row_of(cb);
		qb = col_of(cb);
		if (ra == rb) begin
			na = cell_index(ra, step(qa, dec_s1));
			nb = cell_index(rb, step(qb, dec_s1));
		end else if (qa == qb) begin
			na = cell_index(step(ra, dec_s1), qa);
			nb = cell_index(step(rb, dec_s1), qb);
		end else begin
			na = cell_index(ra, qb);
			nb = cell_index(rb, qa);
		end
	end

	assign tgt_a = tgt_a_s2;
	assign tgt_b = tgt_b_s2;

endmodule

FILE: rtl/playfair_square_cipher_unit.sv
// Pair words: s1, s2 and output regs; one per cycle while out_ready and no fill.
// Key letter word: no result; fills the next cell if new and room remains.
// Finish word: steps one letter per cycle through the alphabet; input
// not ready meanwhile.
// Reset (arst_n low): empties the square count, marks only J as placed, clears valids.
module playfair_square_cipher_unit
	import pfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [4:0] first_letter,
	input  logic [4:0] second_letter,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] first_out,
	output logic [4:0] second_out,
	output logic [4:0] first_out_j,
	output logic [4:0] second_out_j
);

	logic [ALPHABET-1:0] placed_q;
	letter_t             fill_pos_q;
	logic                fill_busy_q;
	letter_t             fill_letter_q;
	logic                v_s1;
	logic                v_s2;
	logic                out_valid_q;
	letter_t             first_out_q;
	letter_t             second_out_q;

	logic                accept;
	logic                en_out;
	pipe_ctrl_t          ctrl;
	logic                place_req;
	letter_t             place_letter;
	logic [31:0]         placed_ext;
	logic                place_en;
	letter_t             key_a;
	letter_t             key_b;
	letter_t             tgt_a;
	letter_t             tgt_b;
	letter_t             sel_a;
	letter_t             sel_b;
	logic [CELLS-1:0]    match_a;
	logic [CELLS-1:0]    match_b;
	letter_t             cells [CELLS];

	assign en_out     = !out_valid_q || out_ready;
	assign ctrl.en_s2 = !v_s2 || en_out;
	assign ctrl.en_s1 = !v_s1 || ctrl.en_s2;
	assign in_ready   = ctrl.en_s1 && !fill_busy_q;
	assign accept     = in_valid && in_ready;

	assign place_req    = fill_busy_q || (accept && op == OP_KEY);
	assign place_letter = fill_busy_q ? fill_letter_q : first_letter;
	assign placed_ext   = {6'h3f, placed_q};
	assign place_en     = place_req && (place_letter <= LAST_LETTER)
		&& (fill_pos_q < FULL_COUNT) && !placed_ext[place_letter];

	assign key_a = fold_j(first_letter);
	assign key_b = fold_j(second_letter);

	for (genvar k = 0; k < CELLS; k++) begin : g_lane
		pfc_lane u_lane (
			.clk     (clk),
			.we      (place_en && fill_pos_q == letter_t'(k)),
			.wdata   (place_letter),
			.key_a   (key_a),
			.key_b   (key_b),
			.stored  (cells[k]),
			.match_a (match_a[k]),
			.match_b (match_b[k])
		);
	end

	pfc_merge u_merge (
		.clk     (clk),
		.ctrl    (ctrl),
		.match_a (match_a),
		.match_b (match_b),
		.dec     (op == OP_DEC),
		.tgt_a   (tgt_a),
		.tgt_b   (tgt_b)
	);

	always_comb begin
		sel_a = '0;
		sel_b = '0;
		for (int k = 0; k < CELLS; k++) begin
			if (tgt_a == letter_t'(k)) begin
				sel_a = sel_a | cells[k];
			end
			if (tgt_b == letter_t'(k)) begin
				sel_b = sel_b | cells[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q      <= PLACED_RESET;
			fill_pos_q    <= '0;
			fill_busy_q   <= 1'b0;
			fill_letter_q <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (place_en) begin
				placed_q[place_letter] <= 1'b1;
				fill_pos_q             <= fill_pos_q + 5'd1;
			end
			if (accept && op == OP_FINISH) begin
				fill_busy_q   <= 1'b1;
				fill_letter_q <= '0;
			end else if (fill_busy_q) begin
				if (fill_letter_q == LAST_LETTER) begin
					fill_busy_q <= 1'b0;
				end else begin
					fill_letter_q <= fill_letter_q + 5'd1;
				end
			end
			if (ctrl.en_s1) begin
				v_s1 <= accept && (op == OP_ENC || op == OP_DEC);
			end
			if (ctrl.en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			first_out_q  <= sel_a;
			second_out_q <= sel_b;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_out    = first_out_q;
	assign second_out   = second_out_q;
	assign first_out_j  = j_form(first_out_q);
	assign second_out_j = j_form(second_out_q);

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_pos_q <= FULL_COUNT)
		else $error("square fill count overran");

	a_j_placed: assert property (@(posedge clk) disable iff (!arst_n)
		placed_q[LETTER_J])
		else $error("J lost its placed mark");

	a_fill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		fill_busy_q |-> !in_ready)
		else $error("input taken during square fill");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && out_valid_q && !out_ready) |=> v_s2)
		else $error("pair word dropped while output stalled");
`endif

endmodule
